@@ rtl/core/mpec_pkg.sv @@
// Shared types, constants and colour-table functions for the escape-time pixel block.
package mpec_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ITER_DEFAULT  = 1024;
   localparam int FRAC_BITS_DEFAULT = 28;

   // Input point format: Q4.28
   localparam int IN_FRAC_BITS = 28;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ITERATIONS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_LIMIT   = 1'd1;

   localparam int MAX_ITER_REG_W = 10;
   localparam int LIMIT_W        = 3;
   localparam logic [MAX_ITER_REG_W-1:0] MAX_ITER_RESET = 10'd255;
   localparam logic [LIMIT_W-1:0]        LIMIT_RESET    = 3'd4;

   // Job queue between front and iteration engine
   localparam int JOB_QUEUE_DEPTH = 2;

   // Result fields
   localparam int COUNT_W = 11;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Black when count*BLACK_DEN > m*BLACK_NUM
   localparam int BLACK_NUM = 84;
   localparam int BLACK_DEN = 100;

   // Colour phases in radians
   localparam logic [63:0] PHASE_RED   = 64'd0;
   localparam logic [63:0] PHASE_GREEN = 64'd120;
   localparam logic [63:0] PHASE_BLUE  = 64'd240;

   // Fixed-point constants for the colour table
   localparam logic [63:0] Q52_TWO_PI  = 64'h006487ED5110B461;
   localparam logic [63:0] Q52_PI      = 64'h003243F6A8885A31;
   localparam logic [63:0] Q52_HALF_PI = 64'h001921FB54442D18;
   localparam longint      Q60_ONE     = 64'sh1000_0000_0000_0000;

   // (2k-1)*2k for the cosine series, k = 1..10
   localparam longint HORNER_DIV [1:10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

   typedef struct packed {
      logic signed [31:0] c_real;
      logic signed [31:0] c_imag;
   } req_type;

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [COUNT_W-1:0] escape_count;
      logic               is_black;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Bitwise integer square root
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] rem;
      logic [63:0] bitv;
      int          i;
      r   = '0;
      rem = x;
      for (i = 0; i < 32; i++) begin
         bitv = 64'd1 << (62 - 2 * i);
         if (rem >= r + bitv) begin
            rem = rem - (r + bitv);
            r   = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // Signed Q.60 product, floored
   function automatic longint mul60(input longint a, input longint b);
      logic signed [127:0] pa;
      logic signed [127:0] pb;
      logic signed [127:0] pr;
      pa = 128'(a);
      pb = 128'(b);
      pr = pa * pb;
      pr = pr >>> 60;
      return longint'(pr[63:0]);
   endfunction

   // floor(255 * cos^2(sqrt(n) + p)), fixed point throughout
   function automatic logic [7:0] shade(input logic [63:0] n, input logic [63:0] p);
      logic [63:0]  s;
      logic [63:0]  phi;
      logic [63:0]  a;
      logic         neg;
      longint       x;
      longint       x2;
      longint       c;
      longint       h;
      logic [127:0] prod;
      int           k;
      s   = isqrt64(n << 52);
      phi = (s << 27) + (p << 53);
      phi = phi % Q52_TWO_PI;
      a   = (phi > Q52_PI) ? Q52_TWO_PI - phi : phi;
      neg = 1'b0;
      if (a > Q52_HALF_PI) begin
         a   = Q52_PI - a;
         neg = 1'b1;
      end
      x  = longint'(a) * 256;
      x2 = mul60(x, x);
      c  = Q60_ONE;
      for (k = 10; k >= 1; k--) begin
         c = Q60_ONE - mul60(x2, c) / HORNER_DIV[k];
      end
      if (neg) begin
         c = -c;
      end
      h = Q60_ONE + c;
      if (h < 0) begin
         h = 0;
      end
      if (h > 2 * Q60_ONE) begin
         h = 2 * Q60_ONE;
      end
      h    = h >>> 1;
      prod = {64'd0, h} * 128'd255;
      return (prod[127:60] > 68'd255) ? 8'd255 : prod[67:60];
   endfunction

   function automatic rgb_type shade_rgb(input logic [63:0] n);
      rgb_type rgb;
      rgb.red   = shade(n, PHASE_RED);
      rgb.green = shade(n, PHASE_GREEN);
      rgb.blue  = shade(n, PHASE_BLUE);
      return rgb;
   endfunction

endpackage

@@ rtl/core/mpec_queue.sv @@
// Small FIFO that decouples the front end from the iteration engine.
module mpec_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [DATA_W-1:0] push_data,
   output logic              valid,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign valid    = (fill_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/mpec_front.sv @@
// Front end: takes a point, rescales c and fixes the iteration bound for the job.
module mpec_front #(
   parameter int MAX_ITER  = mpec_pkg::MAX_ITER_DEFAULT,
   parameter int FRAC_BITS = mpec_pkg::FRAC_BITS_DEFAULT,
   localparam int CW    = FRAC_BITS + 4,
   localparam int CNT_W = $clog2(MAX_ITER + 1),
   localparam int JOB_W = 2 * CW + CNT_W + mpec_pkg::LIMIT_W
) (
   input  logic                                  req_push,
   output logic                                  req_full,
   input  mpec_pkg::req_type                     req_data,
   input  logic [mpec_pkg::MAX_ITER_REG_W-1:0]   max_iterations,
   input  logic [mpec_pkg::LIMIT_W-1:0]          escape_limit,
   output logic                                  job_push,
   input  logic                                  job_full,
   output logic [JOB_W-1:0]                      job_data
);

   localparam int MW = (CNT_W > mpec_pkg::MAX_ITER_REG_W) ? CNT_W : mpec_pkg::MAX_ITER_REG_W;

   logic signed [CW-1:0] cr;
   logic signed [CW-1:0] ci;
   logic [MW-1:0]        iter_cfg;
   logic [MW-1:0]        iter_cap;
   logic [CNT_W-1:0]     last_iter;

   // Q4.28 to FRAC_BITS fraction bits: exact widen, or floor narrow
   if (FRAC_BITS >= mpec_pkg::IN_FRAC_BITS) begin : g_widen
      assign cr = CW'(req_data.c_real) <<< (FRAC_BITS - mpec_pkg::IN_FRAC_BITS);
      assign ci = CW'(req_data.c_imag) <<< (FRAC_BITS - mpec_pkg::IN_FRAC_BITS);
   end else begin : g_narrow
      assign cr = CW'(req_data.c_real >>> (mpec_pkg::IN_FRAC_BITS - FRAC_BITS));
      assign ci = CW'(req_data.c_imag >>> (mpec_pkg::IN_FRAC_BITS - FRAC_BITS));
   end

   // last iteration index = min(max_iterations, MAX_ITER-1)
   assign iter_cfg  = MW'(max_iterations);
   assign iter_cap  = MW'(MAX_ITER - 1);
   assign last_iter = CNT_W'((iter_cfg < iter_cap) ? iter_cfg : iter_cap);

   assign req_full = job_full;
   assign job_push = req_push && !job_full;
   assign job_data = {cr, ci, last_iter, escape_limit};

endmodule

@@ rtl/core/mpec_iter.sv @@
// Escape iteration engine: z = z*z + c on one shared set of squarers.
module mpec_iter #(
   parameter int MAX_ITER  = mpec_pkg::MAX_ITER_DEFAULT,
   parameter int FRAC_BITS = mpec_pkg::FRAC_BITS_DEFAULT,
   localparam int CW    = FRAC_BITS + 4,
   localparam int CNT_W = $clog2(MAX_ITER + 1),
   localparam int JOB_W = 2 * CW + CNT_W + mpec_pkg::LIMIT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_pop,
   input  logic [JOB_W-1:0] job_data,
   output logic             done_valid,
   input  logic             done_ready,
   output logic [CNT_W-1:0] done_count,
   output logic [CNT_W-1:0] done_last
);

   localparam int ZW = FRAC_BITS + 3;       // |z| < 3
   localparam int PW = 2 * ZW;              // products
   localparam int NW = FRAC_BITS + 6;       // new z before range check
   localparam int SW = 2 * FRAC_BITS + 5;   // |z|^2

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic signed [NW-1:0] ESC_MAG = NW'(3) <<< FRAC_BITS;

   logic [1:0]                   state_ff, state_in;
   logic signed [ZW-1:0]         zr_ff, zr_in;
   logic signed [ZW-1:0]         zi_ff, zi_in;
   logic signed [CW-1:0]         cr_ff, cr_in;
   logic signed [CW-1:0]         ci_ff, ci_in;
   logic [CNT_W-1:0]             last_ff, last_in;
   logic [mpec_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic signed [PW-1:0]         prr_ff, prr_in;
   logic signed [PW-1:0]         pii_ff, pii_in;
   logic signed [PW-1:0]         pri_ff, pri_in;

   logic signed [PW:0]           diff_rr;
   logic signed [PW:0]           dbl_ri;
   logic signed [NW-1:0]         nr;
   logic signed [NW-1:0]         ni;
   logic                         in_range;
   logic [SW-1:0]                mag_sq;
   logic [SW-1:0]                bound;

   assign diff_rr  = prr_ff - pii_ff;
   assign dbl_ri   = $signed({pri_ff, 1'b0});
   assign nr       = NW'(diff_rr >>> FRAC_BITS) + NW'(cr_ff);
   assign ni       = NW'(dbl_ri >>> FRAC_BITS) + NW'(ci_ff);
   assign in_range = (nr < ESC_MAG) && (nr > -ESC_MAG) && (ni < ESC_MAG) && (ni > -ESC_MAG);
   // squares of the z left by the previous step
   assign mag_sq   = $unsigned(SW'(prr_ff)) + $unsigned(SW'(pii_ff));
   assign bound    = SW'({limit_ff, {(2 * FRAC_BITS){1'b0}}});

   assign done_valid = (state_ff == ST_DONE);
   assign done_count = count_ff;
   assign done_last  = last_ff;

   always_comb begin
      state_in = state_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      last_in  = last_ff;
      limit_in = limit_ff;
      n_in     = n_ff;
      count_in = count_ff;
      prr_in   = prr_ff;
      pii_in   = pii_ff;
      pri_in   = pri_ff;
      job_pop  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            job_pop = job_valid;
            if (job_valid) begin
               {cr_in, ci_in, last_in, limit_in} = job_data;
               zr_in    = '0;
               zi_in    = '0;
               n_in     = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prr_in   = zr_ff * zr_ff;
            pii_in   = zi_ff * zi_ff;
            pri_in   = zr_ff * zi_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if ((n_ff != '0) && (mag_sq > bound)) begin
               // previous step left the disc
               count_in = n_ff - 1'b1;
               state_in = ST_DONE;
            end else if (n_ff > last_ff) begin
               count_in = n_ff;
               state_in = ST_DONE;
            end else if (!in_range) begin
               // a component of 3 or more is an escape on its own
               count_in = n_ff;
               state_in = ST_DONE;
            end else begin
               zr_in    = ZW'(nr);
               zi_in    = ZW'(ni);
               n_in     = n_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      last_ff  <= last_in;
      limit_ff <= limit_in;
      n_ff     <= n_in;
      count_ff <= count_in;
      prr_ff   <= prr_in;
      pii_ff   <= pii_in;
      pri_ff   <= pri_in;
   end

endmodule

@@ rtl/core/mpec_color.sv @@
// Colour back end: black test, colour table read and result register.
module mpec_color #(
   parameter int MAX_ITER = mpec_pkg::MAX_ITER_DEFAULT,
   localparam int CNT_W = $clog2(MAX_ITER + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              done_valid,
   output logic              done_ready,
   input  logic [CNT_W-1:0]  done_count,
   input  logic [CNT_W-1:0]  done_last,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mpec_pkg::rsp_type rsp_data
);

   // Only counts up to 0.84*(MAX_ITER-1) can be coloured
   localparam int ROM_DEPTH = ((MAX_ITER - 1) * mpec_pkg::BLACK_NUM) / mpec_pkg::BLACK_DEN + 1;
   localparam int ROM_AW    = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
   localparam int SCALE_W   = CNT_W + 7;
   localparam int OUT_CNT_W = mpec_pkg::COUNT_W;

   mpec_pkg::rgb_type color_rom [ROM_DEPTH];

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
      localparam mpec_pkg::rgb_type ENTRY = mpec_pkg::shade_rgb(64'(g));
      assign color_rom[g] = ENTRY;
   end

   logic [SCALE_W-1:0] count_scaled;
   logic [SCALE_W-1:0] last_scaled;
   logic               black;
   logic [ROM_AW-1:0]  rom_addr;
   logic               take;
   logic               advance;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_black_ff;
   logic [CNT_W-1:0]   s1_count_ff;
   mpec_pkg::rgb_type  rgb_ff;
   logic               out_valid_ff, out_valid_in;
   mpec_pkg::rsp_type  out_ff, out_in;

   assign count_scaled = SCALE_W'(done_count) * SCALE_W'(mpec_pkg::BLACK_DEN);
   assign last_scaled  = SCALE_W'(done_last) * SCALE_W'(mpec_pkg::BLACK_NUM);
   assign black        = count_scaled > last_scaled;
   // a non-black count is always inside the table
   assign rom_addr     = black ? '0 : ROM_AW'(done_count);

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_pop);
   assign done_ready = !s1_valid_ff || advance;
   assign take       = done_valid && done_ready;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         s1_valid_in  = 1'b0;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_comb begin
      out_in.red          = s1_black_ff ? 8'd0 : rgb_ff.red;
      out_in.green        = s1_black_ff ? 8'd0 : rgb_ff.green;
      out_in.blue         = s1_black_ff ? 8'd0 : rgb_ff.blue;
      out_in.alpha        = mpec_pkg::ALPHA_OPAQUE;
      out_in.escape_count = OUT_CNT_W'(s1_count_ff);
      out_in.is_black     = s1_black_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_black_ff <= black;
         s1_count_ff <= done_count;
         rgb_ff      <= color_rom[rom_addr];
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

@@ rtl/core/mandelbrot_pixel_escape_color.sv @@
// Top level of the escape-time pixel colouring block.
//
// Usage
//   Points enter on the req_ side like a FIFO write: req_data carries c as
//   two signed Q4.28 words and is transferred when req_push is high and
//   req_full is low. Results leave on the rsp_ side like a FIFO read: the
//   oldest pixel sits on rsp_data while rsp_empty is low and is transferred
//   when rsp_pop is high. One pixel per point, in order. csr_write with
//   csr_index 0 loads max_iterations, index 1 escape_limit; write only idle.
//
// Timing
//   Each z step runs the registered squarers, then the add, range and |z|^2
//   test. The engine holds one point until the range test, the bound m or
//   |z|^2 passing the limit stops it, and takes the next only once its
//   result has left. The engine sets throughput; the colour stage registers
//   the table read and then the result.
//
// Reset and stalls
//   Synchronous, active high: queues empty, engine idle, registers 255 and 4.
//   A stalled rsp_ side holds its result, the colour stage takes one more
//   count, the engine waits with the next, and the two-entry job queue fills.
module mandelbrot_pixel_escape_color #(
   parameter int MAX_ITER  = mpec_pkg::MAX_ITER_DEFAULT,
   parameter int FRAC_BITS = mpec_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  mpec_pkg::req_type                   req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output mpec_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [mpec_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mpec_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW    = FRAC_BITS + 4;
   localparam int CNT_W = $clog2(MAX_ITER + 1);
   localparam int JOB_W = 2 * CW + CNT_W + mpec_pkg::LIMIT_W;

   // Configuration registers
   logic [mpec_pkg::MAX_ITER_REG_W-1:0] max_iter_ff, max_iter_in;
   logic [mpec_pkg::LIMIT_W-1:0]        limit_ff, limit_in;

   always_comb begin
      max_iter_in = max_iter_ff;
      limit_in    = limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            mpec_pkg::CSR_MAX_ITERATIONS: max_iter_in = csr_wdata[mpec_pkg::MAX_ITER_REG_W-1:0];
            mpec_pkg::CSR_ESCAPE_LIMIT:   limit_in    = csr_wdata[mpec_pkg::LIMIT_W-1:0];
            default: begin
               max_iter_in = max_iter_ff;
               limit_in    = limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= mpec_pkg::MAX_ITER_RESET;
         limit_ff    <= mpec_pkg::LIMIT_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
         limit_ff    <= limit_in;
      end
   end

   // Front -> queue -> engine -> colour
   logic             job_push;
   logic             job_full;
   logic [JOB_W-1:0] job_in_data;
   logic             job_valid;
   logic             job_pop;
   logic [JOB_W-1:0] job_out_data;
   logic             done_valid;
   logic             done_ready;
   logic [CNT_W-1:0] done_count;
   logic [CNT_W-1:0] done_last;

   mpec_front #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .max_iterations (max_iter_ff),
      .escape_limit   (limit_ff),
      .job_push       (job_push),
      .job_full       (job_full),
      .job_data       (job_in_data)
   );

   mpec_queue #(
      .DATA_W (JOB_W),
      .DEPTH  (mpec_pkg::JOB_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_in_data),
      .valid     (job_valid),
      .pop       (job_pop),
      .pop_data  (job_out_data)
   );

   mpec_iter #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) u_iter (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .job_data   (job_out_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_count (done_count),
      .done_last  (done_last)
   );

   mpec_color #(
      .MAX_ITER (MAX_ITER)
   ) u_color (
      .clock      (clock),
      .reset      (reset),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_count (done_count),
      .done_last  (done_last),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
